FILE: rtl/rdc_pkg.sv
// rdc_pkg: shared types and codes for range_distinct_count.
// No dependencies.
`timescale 1ns / 1ps
package rdc_pkg;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;
endpackage

FILE: rtl/rdc_front.sv
// rdc_front: input stage and two-entry word queue toward the back end.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module rdc_front
	import rdc_pkg::*;
#(
	parameter int PW = 15,
	parameter int VW = 16,
	parameter int DEPTH = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          valid,
	output logic          stall,
	input  logic          kind,
	input  logic [14:0]   position,
	input  logic [15:0]   element_value,
	input  logic [14:0]   query_left,
	input  logic [14:0]   query_right,
	output logic          q_valid,
	input  logic          q_take,
	output logic          q_kind,
	output logic [PW-1:0] q_pos,
	output logic [VW-1:0] q_val,
	output logic [PW-1:0] q_lo,
	output logic [PW-1:0] q_hi,
	output logic          q_load_ok
);
	typedef struct packed {
		logic          kind;
		logic [PW-1:0] pos;
		logic [VW-1:0] val;
		logic [PW-1:0] lo;
		logic [PW-1:0] hi;
		logic          load_ok;
	} word_t;

	localparam int ADEPTH = DEPTH;
	localparam int XW = ((PW > 15) ? PW : 15) + 1;
	word_t         mem_q [2];
	logic          wp_q, rp_q;
	logic [1:0]    cnt_q;
	word_t         w;
	logic [XW-1:0] pos_ext, lo_ext, hi_ext;
	logic          push, pop;

	assign stall = (cnt_q == 2'd2);
	assign push = valid && !stall;
	assign pop = q_take && (cnt_q != 2'd0);
	assign q_valid = (cnt_q != 2'd0);

	always_comb begin
		pos_ext = XW'(position);
		lo_ext = XW'(query_left);
		hi_ext = XW'(query_right);
		if (hi_ext > XW'(ADEPTH - 1)) hi_ext = XW'(ADEPTH - 1);
		w.kind = kind;
		w.pos = pos_ext[PW-1:0];
		w.load_ok = (pos_ext < XW'(ADEPTH));
		w.val = VW'(element_value);
		w.lo = lo_ext[PW-1:0];
		w.hi = hi_ext[PW-1:0];
		if (lo_ext > hi_ext) begin
			w.lo = PW'(ADEPTH - 1);
			w.hi = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign q_kind = mem_q[rp_q].kind;
	assign q_pos = mem_q[rp_q].pos;
	assign q_val = mem_q[rp_q].val;
	assign q_lo = mem_q[rp_q].lo;
	assign q_hi = mem_q[rp_q].hi;
	assign q_load_ok = mem_q[rp_q].load_ok;
endmodule

FILE: rtl/rdc_back.sv
// rdc_back: window sequencer over element store and count table, result register.
// Depends on rdc_pkg.
`timescale 1ns / 1ps
module rdc_back
	import rdc_pkg::*;
#(
	parameter int PW = 15,
	parameter int VW = 16,
	parameter int DEPTH = 32768
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_take,
	input  logic          q_kind,
	input  logic [PW-1:0] q_pos,
	input  logic [VW-1:0] q_val,
	input  logic [PW-1:0] q_lo,
	input  logic [PW-1:0] q_hi,
	input  logic          q_load_ok,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [15:0]   distinct_count
);
	localparam logic [3:0] ST_CLR = 4'd0, ST_IDLE = 4'd1, ST_RD = 4'd2, ST_RDW = 4'd3,
		ST_CNT = 4'd4, ST_CNTW = 4'd5, ST_UPD = 4'd6, ST_OUT = 4'd7, ST_MOVE = 4'd8;
	localparam int ADEPTH = DEPTH;
	localparam int VDEPTH = 1 << VW;
	localparam int CW = PW + 1;
	localparam int CLRW = ((PW > VW) ? PW : VW) + 1;
	localparam int CLR_LAST = ((ADEPTH > VDEPTH) ? ADEPTH : VDEPTH) - 1;

	logic [VW-1:0]   elem_mem [ADEPTH];
	logic [CW-1:0]   cnt_mem  [VDEPTH];
	logic [3:0]      st_q;
	logic [CLRW-1:0] clr_q;
	logic [PW:0]     ws_q, we_q, stop_q;
	logic [PW-1:0]   lo_q, idx_q, ldpos_q;
	logic [VW-1:0]   ldval_q, v_q, erd_q;
	logic [CW-1:0]   crd_q;
	logic            add_q, ld_q, ldphase_q;
	logic [CW-1:0]   tot_q;
	logic [15:0]     res_q, pend_q;
	logic            ov_q;
	logic            e_we, c_we;
	logic [PW-1:0]   e_wa;
	logic [VW-1:0]   e_wd, c_wa;
	logic [CW-1:0]   c_wd;

	assign q_take = (st_q == ST_IDLE) && q_valid;
	assign out_valid = ov_q;
	assign distinct_count = res_q;

	always_ff @(posedge clk) begin
		if (e_we) elem_mem[e_wa] <= e_wd;
		erd_q <= elem_mem[idx_q];
		if (c_we) cnt_mem[c_wa] <= c_wd;
		crd_q <= cnt_mem[v_q];
	end

	always_comb begin
		e_we = 1'b0; e_wa = ldpos_q; e_wd = ldval_q;
		c_we = 1'b0; c_wa = v_q; c_wd = '0;
		if (st_q == ST_CLR) begin
			e_we = (clr_q < CLRW'(ADEPTH)); e_wa = clr_q[PW-1:0]; e_wd = '0;
			c_we = 1'b1; c_wa = clr_q[VW-1:0];
		end else if (st_q == ST_UPD) begin
			c_we = add_q || (crd_q != '0);
			c_wd = add_q ? crd_q + 1'b1 : crd_q - 1'b1;
			e_we = ld_q && !ldphase_q;
		end else if (st_q == ST_IDLE && q_valid && q_kind == KIND_LOAD && q_load_ok
				&& !(({1'b0, q_pos} >= ws_q) && ({1'b0, q_pos} < we_q))) begin
			e_we = 1'b1; e_wa = q_pos; e_wd = q_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLR; clr_q <= '0; ws_q <= '0; we_q <= '0; tot_q <= '0;
			ov_q <= 1'b0; res_q <= '0; pend_q <= '0;
			ld_q <= 1'b0; ldpos_q <= '0; ldval_q <= '0; lo_q <= '0; stop_q <= '0;
			ldphase_q <= 1'b0; idx_q <= '0; add_q <= 1'b0; v_q <= '0;
		end else begin
			if (ov_q && !out_stall) ov_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRW'(CLR_LAST)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (q_valid) begin
					ld_q <= (q_kind == KIND_LOAD);
					ldpos_q <= q_pos; ldval_q <= q_val;
					lo_q <= q_lo; stop_q <= {1'b0, q_hi} + 1'b1;
					ldphase_q <= 1'b0;
					if (q_kind == KIND_LOAD) begin
						if (q_load_ok && ({1'b0, q_pos} >= ws_q) && ({1'b0, q_pos} < we_q)) begin
							idx_q <= q_pos; add_q <= 1'b0; st_q <= ST_RD;
						end
					end else if (q_lo > q_hi) begin
						pend_q <= '0; st_q <= ST_OUT;
					end else st_q <= ST_MOVE;
				end
				ST_MOVE: begin
					priority if (ws_q > {1'b0, lo_q}) begin
						ws_q <= ws_q - 1'b1; idx_q <= ws_q[PW-1:0] - 1'b1;
						add_q <= 1'b1; st_q <= ST_RD;
					end else if (we_q < stop_q) begin
						we_q <= we_q + 1'b1; idx_q <= we_q[PW-1:0];
						add_q <= 1'b1; st_q <= ST_RD;
					end else if (ws_q < {1'b0, lo_q}) begin
						ws_q <= ws_q + 1'b1; idx_q <= ws_q[PW-1:0];
						add_q <= 1'b0; st_q <= ST_RD;
					end else if (we_q > stop_q) begin
						we_q <= we_q - 1'b1; idx_q <= we_q[PW-1:0] - 1'b1;
						add_q <= 1'b0; st_q <= ST_RD;
					end else begin
						pend_q <= (tot_q > CW'(16'hFFFF)) ? 16'hFFFF : 16'(tot_q);
						st_q <= ST_OUT;
					end
				end
				ST_RD: st_q <= ST_RDW;
				ST_RDW: begin
					v_q <= ld_q && ldphase_q ? ldval_q : erd_q;
					st_q <= ST_CNT;
				end
				ST_CNT: st_q <= ST_CNTW;
				ST_CNTW: st_q <= ST_UPD;
				ST_UPD: begin
					if (add_q && crd_q == '0) tot_q <= tot_q + 1'b1;
					if (!add_q && crd_q == CW'(1) && tot_q != '0) tot_q <= tot_q - 1'b1;
					if (ld_q && !ldphase_q) begin
						ldphase_q <= 1'b1; add_q <= 1'b1; st_q <= ST_RDW;
					end else if (ld_q) st_q <= ST_IDLE;
					else st_q <= ST_MOVE;
				end
				ST_OUT: if (!ov_q || !out_stall) begin
					ov_q <= 1'b1; res_q <= pend_q; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: rtl/range_distinct_count.sv
// range_distinct_count: top level joining the front queue and the window back end.
// Depends on rdc_pkg, rdc_front, rdc_back.
//
// Input channel: valid/stall with kind, position, element_value, query_left,
// query_right. A load (kind 0) writes one element; a query (kind 1) returns one
// distinct_count word on the output channel (out_valid/out_stall).
// The front holds up to two words in a queue, so input is taken while the back
// end is busy. A load inside the window also takes the old value out of the count
// table and adds the new one. An empty query returns zero without moving the
// window; otherwise each element the window edges move costs one element-store
// read and one count-table read-modify-write. Results leave in order through one
// output register; while out_stall is high the word holds and the back end waits
// after finishing the next query. After reset the back end clears both stores,
// one entry per cycle, over max(ARRAY_DEPTH, 2^VALUE_BITS) entries; words queue
// meanwhile.
`timescale 1ns / 1ps
module range_distinct_count
	import rdc_pkg::*;
#(
	parameter int ARRAY_DEPTH = 32768,
	parameter int VALUE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        stall,
	input  logic        kind,
	input  logic [14:0] position,
	input  logic [15:0] element_value,
	input  logic [14:0] query_left,
	input  logic [14:0] query_right,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] distinct_count
);
	localparam int PW = $clog2(ARRAY_DEPTH);
	logic          q_valid, q_take, q_kind, q_load_ok;
	logic [PW-1:0] q_pos, q_lo, q_hi;
	logic [VALUE_BITS-1:0] q_val;

	rdc_front #(.PW(PW), .VW(VALUE_BITS), .DEPTH(ARRAY_DEPTH)) u_front (
		.clk, .arst_n, .valid, .stall, .kind, .position, .element_value,
		.query_left, .query_right, .q_valid, .q_take, .q_kind, .q_pos, .q_val,
		.q_lo, .q_hi, .q_load_ok
	);

	rdc_back #(.PW(PW), .VW(VALUE_BITS), .DEPTH(ARRAY_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_kind, .q_pos, .q_val, .q_lo, .q_hi,
		.q_load_ok, .out_valid, .out_stall, .distinct_count
	);
endmodule
